### rtl/core/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check under synchronous reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication check under synchronous reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### rtl/core/rnc_pkg.sv
// shared types and constants for the normalized convolution block
// no dependencies
`default_nettype none
package rnc_pkg;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_KERNEL_DEF = 5;
  localparam int SIDE_W = 12;
  localparam int KS_W   = 3;
  localparam int POS_W  = 11;
  localparam int PIX_W  = 24;
  localparam int COEF_W = 16;

  localparam logic [0:0] CFG_IMAGE_SIDE  = 1'b0;
  localparam logic [0:0] CFG_KERNEL_SIDE = 1'b1;
  localparam logic       MODE_COEF = 1'b0;
  localparam logic       MODE_PIX  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [4:0]  coef_index;
    logic [15:0] coef_value;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic        frame_last;
    logic        zero_norm;
  } out_item_t;

  // job handed from window engine to divider
  typedef struct packed {
    logic [39:0] acc_r;
    logic [39:0] acc_g;
    logic [39:0] acc_b;
    logic [23:0] norm;
    logic [10:0] row;
    logic [10:0] col;
    logic        last;
  } div_job_t;
endpackage
`default_nettype wire

### rtl/core/rgb_normalized_convolution_top.sv
// top level of the normalized 2d convolution block
// depends on rnc_pkg, rnc_window, rnc_divider
//
// input channel in_valid/in_stall/in_data: coefficient loads (mode 0) do
//   not raise in_stall; pixel transfers stream in raster order
// a pixel that completes a k x k window starts a multiply-accumulate pass
//   over the line memory, one window tap per cycle; in_stall stays high
//   until the divider takes the sums
// the divider then runs 40 bit-serial steps for the three channels in
//   parallel plus an output state, overlapping with the next window;
//   it takes a new job only after its last result is in the output register
// pixels that complete no window do not raise in_stall
// output channel out_valid/out_stall/out_data: result held in an output
//   register; a stalled result holds and back-pressures the divider and
//   then the input
// cfg_we/cfg_index/cfg_wdata write image_side (0) and kernel_side (1) and
//   restart the frame
// synchronous reset clears counters and handshakes; line and coefficient
//   memories are not cleared
`default_nettype none
module rgb_normalized_convolution_top
  import rnc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);
  logic     job_valid, job_take;
  div_job_t job;

  rnc_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_window (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_stall, .in_data,
    .job_valid, .job_take, .job
  );

  rnc_divider u_divider (
    .clk, .rst_n, .job_valid, .job_take, .job, .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

### rtl/core/rnc_window.sv
// window engine: line memory, coefficient memory and multiply-accumulate sequencer
// depends on rnc_pkg
`default_nettype none
module rnc_window
  import rnc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             job_valid,
  input  wire logic        job_take,
  output div_job_t         job
);
  localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;
  localparam int CI_W  = $clog2(NCOEF);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int LW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [PIX_W-1:0]  line_mem [DEPTH];
  logic [COEF_W-1:0] coef_mem [NCOEF];

  logic [SIDE_W-1:0] side_r;
  logic [KS_W-1:0]   ks_r;
  logic [POS_W-1:0]  row_r, col_r;
  logic [LW-1:0]     lrow_r;
  logic [1:0]        state_r, state_nxt;

  logic [SIDE_W:0]   side_eff;
  logic [KW-1:0]     k_eff;
  always_comb begin
    if (side_r == '0) side_eff = (SIDE_W+1)'(1);
    else if ({1'b0, side_r} > (SIDE_W+1)'(MAX_WIDTH)) side_eff = (SIDE_W+1)'(MAX_WIDTH);
    else side_eff = {1'b0, side_r};
    if (ks_r == '0) k_eff = KW'(1);
    else if (32'(ks_r) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
    else k_eff = KW'(ks_r);
  end

  // sequencing state
  logic [KW-1:0]    kr_r, kc_r;
  logic [LW-1:0]    cur_line_r;
  logic [POS_W-1:0] top_r, left_r;
  logic             last_r;
  logic [CI_W-1:0]  ci_r;
  logic             rd_v_r, rd_lastw_r;
  logic [PIX_W-1:0] px_q_r;
  logic [COEF_W-1:0] w_q_r;
  logic [39:0] acc_r_r, acc_g_r, acc_b_r;
  logic [23:0] norm_r;
  logic        prod_v_r, prod_last_r;
  logic [23:0] pr_r, pg_r, pb_r;
  logic [COEF_W-1:0] pw_r;
  logic        done_r;

  wire pix_fire  = in_valid && !in_stall && in_data.mode == MODE_PIX;
  wire coef_fire = in_valid && !in_stall && in_data.mode == MODE_COEF;

  assign in_stall = state_r != ST_IDLE;

  wire [SIDE_W:0] r_ext = {2'b0, row_r};
  wire [SIDE_W:0] c_ext = {2'b0, col_r};
  wire win_ok = ({{(SIDE_W+1-KW){1'b0}}, k_eff} <= side_eff) &&
                (r_ext + 1'b1 >= {{(SIDE_W+1-KW){1'b0}}, k_eff}) &&
                (c_ext + 1'b1 >= {{(SIDE_W+1-KW){1'b0}}, k_eff});
  wire frame_end = (r_ext == side_eff - 1'b1) && (c_ext == side_eff - 1'b1);

  // line ring index of the window top
  logic [LW-1:0] top_line;
  always_comb begin
    logic [LW:0] t;
    t = {1'b0, lrow_r} + (LW+1)'(MAX_KERNEL) + (LW+1)'(1) - (LW+1)'(k_eff);
    top_line = (t >= (LW+1)'(MAX_KERNEL)) ? LW'(t - (LW+1)'(MAX_KERNEL)) : LW'(t);
  end

  wire last_read = (kr_r == k_eff - 1'b1) && (kc_r == k_eff - 1'b1);
  wire [AW-1:0] rd_addr = AW'(cur_line_r) * AW'(MAX_WIDTH) + AW'(left_r[XW-1:0]) + AW'(kc_r);
  wire [AW-1:0] wr_addr = AW'(lrow_r) * AW'(MAX_WIDTH) + AW'(col_r[XW-1:0]);

  always_ff @(posedge clk) begin
    if (pix_fire) line_mem[wr_addr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    if (coef_fire && 32'(in_data.coef_index) < NCOEF)
      coef_mem[in_data.coef_index[CI_W-1:0]] <= in_data.coef_value;
    px_q_r <= line_mem[rd_addr];
    w_q_r  <= coef_mem[ci_r];
  end

  // sums stay put until the divider has taken them
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pix_fire && win_ok) state_nxt = ST_RUN;
      ST_RUN:  if (last_read) state_nxt = ST_WAIT;
      ST_WAIT: if (job_valid && job_take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      side_r <= 12'd2048; ks_r <= 3'd3;
      row_r <= '0; col_r <= '0; lrow_r <= '0;
      rd_v_r <= 1'b0; prod_v_r <= 1'b0; done_r <= 1'b0; job_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_SIDE) side_r <= cfg_wdata;
        else ks_r <= cfg_wdata[KS_W-1:0];
        row_r <= '0; col_r <= '0; lrow_r <= '0;
      end else if (pix_fire) begin
        if (c_ext + 1'b1 >= side_eff) begin
          col_r <= '0;
          if (r_ext + 1'b1 >= side_eff) begin
            row_r <= '0; lrow_r <= '0;
          end else begin
            row_r <= row_r + 1'b1;
            lrow_r <= (32'(lrow_r) == MAX_KERNEL - 1) ? '0 : lrow_r + 1'b1;
          end
        end else col_r <= col_r + 1'b1;
      end
      if (state_r == ST_IDLE && pix_fire && win_ok) begin
        kr_r <= '0; kc_r <= '0; ci_r <= '0;
        cur_line_r <= top_line;
        top_r  <= POS_W'(r_ext + 1'b1 - {{(SIDE_W+1-KW){1'b0}}, k_eff});
        left_r <= POS_W'(c_ext + 1'b1 - {{(SIDE_W+1-KW){1'b0}}, k_eff});
        last_r <= frame_end;
        acc_r_r <= '0; acc_g_r <= '0; acc_b_r <= '0; norm_r <= '0;
        done_r <= 1'b0;
      end
      // read stage
      rd_v_r <= state_r == ST_RUN;
      rd_lastw_r <= state_r == ST_RUN && last_read;
      if (state_r == ST_RUN) begin
        ci_r <= ci_r + 1'b1;
        if (kc_r == k_eff - 1'b1) begin
          kc_r <= '0; kr_r <= kr_r + 1'b1;
          cur_line_r <= (32'(cur_line_r) == MAX_KERNEL - 1) ? '0 : cur_line_r + 1'b1;
        end else kc_r <= kc_r + 1'b1;
      end
      // multiply stage
      prod_v_r <= rd_v_r;
      prod_last_r <= rd_lastw_r;
      pr_r <= px_q_r[23:16] * w_q_r;
      pg_r <= px_q_r[15:8] * w_q_r;
      pb_r <= px_q_r[7:0] * w_q_r;
      pw_r <= w_q_r;
      // accumulate stage
      if (prod_v_r) begin
        acc_r_r <= acc_r_r + 40'(pr_r);
        acc_g_r <= acc_g_r + 40'(pg_r);
        acc_b_r <= acc_b_r + 40'(pb_r);
        norm_r  <= norm_r + 24'(pw_r);
        if (prod_last_r) done_r <= 1'b1;
      end
      if (done_r && state_r == ST_WAIT && !job_valid) begin
        job_valid <= 1'b1; done_r <= 1'b0;
      end else if (job_take) job_valid <= 1'b0;
    end
  end

  assign job = '{acc_r: acc_r_r, acc_g: acc_g_r, acc_b: acc_b_r, norm: norm_r,
                 row: top_r, col: left_r, last: last_r};
endmodule
`default_nettype wire

### rtl/core/rnc_divider.sv
// restoring divider for three channel sums, one quotient bit per cycle, with output register
// depends on rnc_pkg
`default_nettype none
module rnc_divider
  import rnc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  output logic           job_take,
  input  wire div_job_t  job,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state_r;
  logic [5:0]  cnt_r;
  logic [39:0] q_r [3];
  logic [24:0] rem_r [3];
  logic [23:0] d_r;
  logic [10:0] row_r, col_r;
  logic        last_r;

  assign job_take = state_r == ST_IDLE && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (job_valid) begin
          q_r[0] <= job.acc_r; q_r[1] <= job.acc_g; q_r[2] <= job.acc_b;
          for (int i = 0; i < 3; i++) rem_r[i] <= '0;
          d_r <= job.norm; row_r <= job.row; col_r <= job.col; last_r <= job.last;
          cnt_r <= 6'd40; state_r <= ST_DIV;
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            logic [24:0] t;
            t = {rem_r[i][23:0], q_r[i][39]};
            if (t >= {1'b0, d_r}) begin
              rem_r[i] <= t - {1'b0, d_r}; q_r[i] <= {q_r[i][38:0], 1'b1};
            end else begin
              rem_r[i] <= t; q_r[i] <= {q_r[i][38:0], 1'b0};
            end
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd1) state_r <= ST_OUT;
        end
        ST_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data.red_out   <= (d_r == '0) ? 8'd0 : q_r[0][7:0];
          out_data.green_out <= (d_r == '0) ? 8'd0 : q_r[1][7:0];
          out_data.blue_out  <= (d_r == '0) ? 8'd0 : q_r[2][7:0];
          out_data.out_row <= row_r; out_data.out_col <= col_r;
          out_data.frame_last <= last_r; out_data.zero_norm <= d_r == '0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (out_valid && !out_stall && !(state_r == ST_OUT)) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rnc_checker.sv
// port-level checker for the normalized convolution block, bound to the top level
// depends on rnc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module rnc_checker
  import rnc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `CHK_IMPL(a_zero_rgb, clk, rst_n, out_valid && out_data.zero_norm, out_data.red_out == 8'd0 && out_data.green_out == 8'd0 && out_data.blue_out == 8'd0)
  `CHK_NEXT(a_coef_no_stall, clk, rst_n, in_valid && !in_stall && in_data.mode == MODE_COEF, !in_stall)
  `CHK_IMPL(a_last_pos, clk, rst_n, out_valid && out_data.frame_last, out_data.out_row == out_data.out_col)
endmodule
bind rgb_normalized_convolution_top rnc_checker u_rnc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
`default_nettype wire
